/* hw/rtl/sip_stream_message_framer_assert.svh */
// ---------------------------------------------------------------------------
// assertion macros for the sip stream message framer
// ---------------------------------------------------------------------------
`ifndef SIP_STREAM_MESSAGE_FRAMER_ASSERT_SVH
`define SIP_STREAM_MESSAGE_FRAMER_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define SIPF_ASSERT_SAME(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);

`define SIPF_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`else

`define SIPF_ASSERT_SAME(lbl, cond, prop, msg)

`define SIPF_ASSERT_NEXT(lbl, cond, prop, msg)

`endif

`endif

/* hw/rtl/sipf_pkg.sv */
// ---------------------------------------------------------------------------
// sipf_pkg
// types, character codes and the header name table of the message framer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sipf_pkg;

  localparam int LENGTH_BITS = 24;
  localparam int CFG_W = 24;
  localparam int PROD_W = LENGTH_BITS + 4;
  localparam int CMP_W = (PROD_W > CFG_W) ? PROD_W : CFG_W;
  localparam int NAME_LEN = 15;
  localparam int NAME_IDX_W = 4;

  localparam logic [7:0] CHAR_CR = 8'h0d;
  localparam logic [7:0] CHAR_LF = 8'h0a;
  localparam logic [7:0] CHAR_SP = 8'h20;
  localparam logic [7:0] CHAR_TAB = 8'h09;
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;
  localparam logic [7:0] CHAR_C = 8'h43;

  localparam logic [1:0] PH_NAME = 2'd0;
  localparam logic [1:0] PH_BLANK = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       connection_closed;
  } sipf_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       first_of_message;
    logic       last_of_message;
    logic       in_body;
    logic       length_error;
    logic       aborted;
  } sipf_out_t;

  typedef struct packed {
    logic [1:0]             phase;
    logic [NAME_IDX_W-1:0]  name_idx;
    logic [LENGTH_BITS-1:0] acc;
    logic                   ovf;
  } sipf_len_state_t;

  function automatic logic [7:0] name_byte(input logic [NAME_IDX_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0: c = 8'h43;
      4'd1: c = 8'h6f;
      4'd2: c = 8'h6e;
      4'd3: c = 8'h74;
      4'd4: c = 8'h65;
      4'd5: c = 8'h6e;
      4'd6: c = 8'h74;
      4'd7: c = 8'h2d;
      4'd8: c = 8'h4c;
      4'd9: c = 8'h65;
      4'd10: c = 8'h6e;
      4'd11: c = 8'h67;
      4'd12: c = 8'h74;
      4'd13: c = 8'h68;
      4'd14: c = 8'h3a;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/sipf_len_track.sv */
// ---------------------------------------------------------------------------
// sipf_len_track
// content-length name match, blank skip and decimal accumulate for one byte
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sipf_len_track (
  input  sipf_pkg::sipf_len_state_t     cur,
  input  logic [7:0]                    data_byte,
  input  logic [sipf_pkg::CMP_W-1:0]    limit,
  output sipf_pkg::sipf_len_state_t     nxt
);

  logic                           digit;
  logic                           blank;
  logic                           do_digit;
  logic [sipf_pkg::PROD_W-1:0]    prod;

  assign digit = (data_byte >= sipf_pkg::CHAR_0) && (data_byte <= sipf_pkg::CHAR_9);
  assign blank = (data_byte == sipf_pkg::CHAR_SP) || (data_byte == sipf_pkg::CHAR_TAB);
  assign prod = sipf_pkg::PROD_W'({cur.acc, 3'b000}) + sipf_pkg::PROD_W'({cur.acc, 1'b0})
              + sipf_pkg::PROD_W'(data_byte[3:0]);

  always_comb begin
    nxt = cur;
    do_digit = 1'b0;
    case (cur.phase)
      sipf_pkg::PH_NAME: begin
        if ((cur.name_idx < sipf_pkg::NAME_IDX_W'(sipf_pkg::NAME_LEN))
            && (data_byte == sipf_pkg::name_byte(cur.name_idx))) begin
          if (cur.name_idx == sipf_pkg::NAME_IDX_W'(sipf_pkg::NAME_LEN - 1)) begin
            nxt.phase = sipf_pkg::PH_BLANK;
            nxt.name_idx = '0;
          end else begin
            nxt.name_idx = cur.name_idx + 1'b1;
          end
        end else begin
          nxt.name_idx = (data_byte == sipf_pkg::CHAR_C) ? sipf_pkg::NAME_IDX_W'(1) : '0;
        end
      end
      sipf_pkg::PH_BLANK: begin
        if (!blank) begin
          if (digit) begin
            nxt.phase = sipf_pkg::PH_DIGITS;
            do_digit = 1'b1;
          end else begin
            nxt.phase = sipf_pkg::PH_DONE;
          end
        end
      end
      sipf_pkg::PH_DIGITS: begin
        if (!digit) begin
          nxt.phase = sipf_pkg::PH_DONE;
        end else begin
          do_digit = 1'b1;
        end
      end
      default: begin
        nxt = cur;
      end
    endcase
    if (do_digit && !cur.ovf) begin
      if (sipf_pkg::CMP_W'(prod) > limit) begin
        nxt.ovf = 1'b1;
      end else begin
        nxt.acc = prod[sipf_pkg::LENGTH_BITS-1:0];
      end
    end
  end

endmodule

/* hw/rtl/sipf_out_reg.sv */
// ---------------------------------------------------------------------------
// sipf_out_reg
// result register with valid and stall, loads while the receiver drains it
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sipf_out_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                accept,
  input  sipf_pkg::sipf_out_t item_next,
  output logic                res_valid,
  input  logic                res_stall,
  output sipf_pkg::sipf_out_t res_item
);

  assign in_stall = res_valid && res_stall;
  assign accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_item <= item_next;
    end
  end

endmodule

/* hw/rtl/sip_stream_message_framer.sv */
// ---------------------------------------------------------------------------
// sip_stream_message_framer
// frames a sip byte stream by header end and content-length
// ---------------------------------------------------------------------------
// usage:
//   in channel (in_valid, in_stall, in_item) takes one stream byte or a
//   connection close per item. res channel (res_valid, res_stall, res_item)
//   returns one tagged item for every input item, in order.
//   cfg_we with cfg_data writes max_body_bytes; write only while idle.
// timing:
//   one item per cycle unless res_stall holds the output; each item is loaded
//   into the output register as it is taken. header scan, length parse and
//   body count all settle in one pass of logic ahead of that register.
// stall:
//   while the output register holds an item and res_stall is high, in_stall
//   is high and no input item is taken; the held item does not change.
// reset:
//   rst (synchronous) clears framing state and res_valid and sets
//   max_body_bytes to its largest value. no clearing pass is needed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "sip_stream_message_framer_assert.svh"

module sip_stream_message_framer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  sipf_pkg::sipf_in_t        in_item,
  output logic                      res_valid,
  input  logic                      res_stall,
  output sipf_pkg::sipf_out_t       res_item,
  input  logic                      cfg_we,
  input  logic [sipf_pkg::CFG_W-1:0] cfg_data
);

  localparam logic [sipf_pkg::CMP_W-1:0] LEN_MASK =
    sipf_pkg::CMP_W'({sipf_pkg::LENGTH_BITS{1'b1}});

  logic [sipf_pkg::CFG_W-1:0]       max_body_bytes;
  logic [1:0]                       term_match;
  logic [1:0]                       term_match_next;
  sipf_pkg::sipf_len_state_t        len_st;
  sipf_pkg::sipf_len_state_t        len_st_next;
  sipf_pkg::sipf_len_state_t        len_trk;
  logic [sipf_pkg::LENGTH_BITS-1:0] body_remaining;
  logic [sipf_pkg::LENGTH_BITS-1:0] body_remaining_next;
  logic [sipf_pkg::LENGTH_BITS-1:0] rem_dec;
  logic [sipf_pkg::LENGTH_BITS-1:0] body_len;
  logic                             in_body_flag;
  logic                             in_body_flag_next;
  logic                             message_started;
  logic                             message_started_next;
  logic [sipf_pkg::CMP_W-1:0]       cfg_wide;
  logic [sipf_pkg::CMP_W-1:0]       limit;
  logic                             accept;
  logic [7:0]                       b;
  sipf_pkg::sipf_out_t              item_next;

  assign b = in_item.data_byte;
  assign cfg_wide = sipf_pkg::CMP_W'(max_body_bytes);
  assign limit = (cfg_wide < LEN_MASK) ? cfg_wide : LEN_MASK;
  assign rem_dec = body_remaining - 1'b1;
  assign body_len = len_trk.ovf ? '0 : len_trk.acc;

  sipf_len_track u_len_track (
    .cur       (len_st),
    .data_byte (b),
    .limit     (limit),
    .nxt       (len_trk)
  );

  always_comb begin
    item_next = '0;
    term_match_next = term_match;
    len_st_next = len_st;
    body_remaining_next = body_remaining;
    in_body_flag_next = in_body_flag;
    message_started_next = message_started;
    if (in_item.connection_closed) begin
      item_next.aborted = message_started;
      term_match_next = '0;
      len_st_next = '0;
      body_remaining_next = '0;
      in_body_flag_next = 1'b0;
      message_started_next = 1'b0;
    end else begin
      item_next.out_byte = b;
      item_next.out_valid = 1'b1;
      if (!message_started) begin
        item_next.first_of_message = 1'b1;
        message_started_next = 1'b1;
      end
      if (in_body_flag) begin
        item_next.in_body = 1'b1;
        body_remaining_next = rem_dec;
        if (rem_dec == '0) begin
          item_next.last_of_message = 1'b1;
          term_match_next = '0;
          len_st_next = '0;
          in_body_flag_next = 1'b0;
          message_started_next = 1'b0;
        end
      end else begin
        len_st_next = len_trk;
        if (term_match == 2'd3 && b == sipf_pkg::CHAR_LF) begin
          // header end: start the body count or close a body-less message
          item_next.length_error = len_trk.ovf;
          term_match_next = '0;
          len_st_next = '0;
          body_remaining_next = body_len;
          if (body_len == '0) begin
            item_next.last_of_message = 1'b1;
            in_body_flag_next = 1'b0;
            message_started_next = 1'b0;
          end else begin
            in_body_flag_next = 1'b1;
            message_started_next = 1'b1;
          end
        end else if (!term_match[0] && b == sipf_pkg::CHAR_CR) begin
          term_match_next = term_match + 1'b1;
        end else if (term_match[0] && b == sipf_pkg::CHAR_LF) begin
          term_match_next = term_match + 1'b1;
        end else begin
          term_match_next = (b == sipf_pkg::CHAR_CR) ? 2'd1 : 2'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_bytes <= '1;
      term_match <= '0;
      len_st <= '0;
      body_remaining <= '0;
      in_body_flag <= 1'b0;
      message_started <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_body_bytes <= cfg_data;
      end
      if (accept) begin
        term_match <= term_match_next;
        len_st <= len_st_next;
        body_remaining <= body_remaining_next;
        in_body_flag <= in_body_flag_next;
        message_started <= message_started_next;
      end
    end
  end

  sipf_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .accept    (accept),
    .item_next (item_next),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  `SIPF_ASSERT_SAME(a_body_started, in_body_flag, message_started, "body without message")
  `SIPF_ASSERT_SAME(a_body_count, in_body_flag, body_remaining != '0, "body count empty")
  `SIPF_ASSERT_SAME(a_name_idle, len_st.phase != sipf_pkg::PH_NAME, len_st.name_idx == '0, "name index live")
  `SIPF_ASSERT_NEXT(a_close_clears, accept && in_item.connection_closed, !message_started && !in_body_flag, "close kept state")
  `SIPF_ASSERT_SAME(a_err_last, res_valid && res_item.length_error, res_item.last_of_message, "length error not last")

endmodule
